// ===== sv/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion block.
// Used by every module of the block; depends on nothing.
package rmq_pkg;

  localparam int FRAC_BITS_DEF   = 14;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Width of the signed unnormalized components.
  localparam int CW    = 34;
  // Width of a component magnitude; every magnitude stays below 2^31.
  localparam int MAG_W = 31;
  localparam int SH_W  = 5;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int N2_W  = 64;
  localparam int NRM_W = 32;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } out_item_t;

  // Classified item: unnormalized (w, x, y, z), flag for a pivot <= 0.
  typedef struct packed {
    logic [3:0][CW-1:0] c;
    logic               degen;
  } cls_item_t;

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion (Shepperd branch choice), fixed point.
// Top level; depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
// Input side is a queue write port: a 3x3 matrix in in_data is taken at a
// clock edge with push high and full low. Result side is a queue read port:
// while empty is low, out_data holds the oldest quaternion, and it is taken
// at an edge with pop high. One item per cycle is accepted and delivered
// when the receiver keeps pop high.
// From acceptance to the result showing, an item passes one front stage, the
// queue, six scaling and sum-of-squares stages, a 32 stage square root (one
// root bit per stage), a divider set-up register, FRAC_BITS + 2 divider
// stages (one quotient bit per stage, four lanes) and the result register.
// When pop stays low, the back end holds; the front end and its queue keep
// taking items until the queue and the front register are both full, and
// then full rises. Synchronous reset (rst_n low) empties every stage and
// the queue; no result is pending afterwards.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS   = rmq_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rmq_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output rmq_pkg::out_item_t out_data
);
  import rmq_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  cls_item_t q_wdata;
  cls_item_t q_rdata;

  rmq_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  rmq_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  rmq_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_degen_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.degenerate) |->
      (out_data.quat_x == 16'sd0 && out_data.quat_y == 16'sd0 && out_data.quat_z == 16'sd0))
    else $error("degenerate result is not the identity");

  a_full_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_full)
    else $error("input stalled while the queue has room");

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");
`endif

endmodule

// ===== sv/rmq_front.sv =====
// Front end: accepts a matrix, picks the branch and forms the unnormalized quaternion.
// Depends on rmq_pkg.
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  rmq_pkg::in_item_t  in_data,
  output logic               q_push,
  output rmq_pkg::cls_item_t q_data,
  input  logic               q_full
);
  import rmq_pkg::*;

  logic              f_valid_r;
  cls_item_t         f_item_r;
  cls_item_t         f_item_nxt;
  logic signed [CW-1:0] r [9];
  logic signed [CW-1:0] one_c;
  logic              take;

  assign one_c = CW'(1) <<< FRAC_BITS;
  assign r[0] = CW'(in_data.r00);
  assign r[1] = CW'(in_data.r01);
  assign r[2] = CW'(in_data.r02);
  assign r[3] = CW'(in_data.r10);
  assign r[4] = CW'(in_data.r11);
  assign r[5] = CW'(in_data.r12);
  assign r[6] = CW'(in_data.r20);
  assign r[7] = CW'(in_data.r21);
  assign r[8] = CW'(in_data.r22);

  always_comb begin
    logic signed [CW-1:0] tr;
    logic signed [CW-1:0] c0, c1, c2, c3, pivot;
    tr = r[0] + r[4] + r[8];
    if (tr > 0) begin
      c0 = tr + one_c;
      c1 = r[7] - r[5];
      c2 = r[2] - r[6];
      c3 = r[3] - r[1];
      pivot = c0;
    end else if (r[0] > r[4] && r[0] > r[8]) begin
      c0 = r[7] - r[5];
      c1 = one_c + r[0] - r[4] - r[8];
      c2 = r[1] + r[3];
      c3 = r[2] + r[6];
      pivot = c1;
    end else if (r[4] > r[8]) begin
      c0 = r[2] - r[6];
      c1 = r[1] + r[3];
      c2 = one_c + r[4] - r[0] - r[8];
      c3 = r[5] + r[7];
      pivot = c2;
    end else begin
      c0 = r[3] - r[1];
      c1 = r[2] + r[6];
      c2 = r[5] + r[7];
      c3 = one_c + r[8] - r[0] - r[4];
      pivot = c3;
    end
    f_item_nxt.c[0] = c0;
    f_item_nxt.c[1] = c1;
    f_item_nxt.c[2] = c2;
    f_item_nxt.c[3] = c3;
    // A pivot that is not positive means the matrix is not a rotation.
    f_item_nxt.degen = (pivot <= 0);
  end

  assign full   = f_valid_r && q_full;
  assign take   = push && !full;
  assign q_push = f_valid_r && !q_full;
  assign q_data = f_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (take) begin
      f_valid_r <= 1'b1;
    end else if (q_push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

// ===== sv/rmq_fifo.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on rmq_pkg.
module rmq_fifo #(
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rmq_pkg::cls_item_t wdata,
  output logic               full,
  input  logic               pop,
  output rmq_pkg::cls_item_t rdata,
  output logic               empty
);
  import rmq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/rmq_sqrt.sv =====
// Pipelined floor integer square root, one result bit per stage, with a side payload.
// Depends on rmq_pkg.
module rmq_sqrt #(
  parameter int PAY_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [rmq_pkg::N2_W-1:0]  in_rad,
  input  logic [PAY_W-1:0]          in_pay,
  output logic                      out_valid,
  output logic [rmq_pkg::NRM_W-1:0] out_root,
  output logic [PAY_W-1:0]          out_pay
);
  import rmq_pkg::*;

  localparam int ST = NRM_W;
  localparam int RW = NRM_W + 3;

  logic             v_r    [0:ST];
  logic [N2_W-1:0]  rad_r  [0:ST];
  logic [RW-1:0]    rem_r  [0:ST];
  logic [NRM_W-1:0] root_r [0:ST];
  logic [PAY_W-1:0] pay_r  [0:ST];

  assign v_r[0]    = in_valid;
  assign rad_r[0]  = in_rad;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign pay_r[0]  = in_pay;

  for (genvar k = 0; k < ST; k++) begin : g_stage
    logic [RW-1:0] rem_nxt;
    logic [RW-1:0] trial;
    logic          ge;

    // The remainder never exceeds twice the partial root, so its top bits drop.
    assign rem_nxt = {rem_r[k][RW-3:0], rad_r[k][N2_W-1 -: 2]};
    assign trial   = {1'b0, root_r[k], 2'b01};
    assign ge      = (rem_nxt >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? rem_nxt - trial : rem_nxt;
        root_r[k+1] <= {root_r[k][NRM_W-2:0], ge};
        rad_r[k+1]  <= rad_r[k] << 2;
        pay_r[k+1]  <= pay_r[k];
      end
    end
  end

  assign out_valid = v_r[ST];
  assign out_root  = root_r[ST];
  assign out_pay   = pay_r[ST];

endmodule

// ===== sv/rmq_back.sv =====
// Back end: magnitude scaling, sum of squares, square root, four lane division, result register.
// Depends on rmq_pkg and rmq_sqrt.
module rmq_back #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  rmq_pkg::cls_item_t q_data,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output rmq_pkg::out_item_t out_data
);
  import rmq_pkg::*;

  localparam int QW    = FRAC_BITS + 2;
  localparam int NW    = FRAC_BITS + MAG_W + 1;
  localparam int PAY_W = 4 * MAG_W + 5;
  localparam logic signed [15:0] IDENT_W =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);

  logic en;
  logic out_valid_r;

  // The whole back end moves together; it holds only while a result waits.
  assign en    = !out_valid_r || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_valid_r;

  // Stage 1: magnitudes and their maximum.
  logic [MAG_W-1:0] mag_c [4];
  logic [MAG_W-1:0] mx_c;
  logic             v1_r;
  logic [MAG_W-1:0] mag1_r [4];
  logic [3:0]       neg1_r;
  logic             deg1_r;
  logic [MAG_W-1:0] mx1_r;

  always_comb begin
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] a;
    mx_c = '0;
    for (int i = 0; i < 4; i++) begin
      cs = $signed(q_data.c[i]);
      a  = (cs < 0) ? -cs : cs;
      mag_c[i] = a[MAG_W-1:0];
      if (mag_c[i] > mx_c) begin
        mx_c = mag_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag1_r[i] <= mag_c[i];
        neg1_r[i] <= q_data.c[i][CW-1];
      end
      deg1_r <= q_data.degen;
      mx1_r  <= mx_c;
    end
  end

  // Stage 2: shift that brings the largest magnitude to bit 30.
  logic [SH_W-1:0]  sh_c;
  logic             v2_r;
  logic [MAG_W-1:0] mag2_r [4];
  logic [3:0]       neg2_r;
  logic             deg2_r;
  logic [SH_W-1:0]  sh2_r;

  always_comb begin
    sh_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx1_r[i]) begin
        sh_c = SH_W'(MAG_W - 1 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      deg2_r <= deg1_r;
      sh2_r  <= sh_c;
    end
  end

  // Stage 3: scaled magnitudes.
  logic             v3_r;
  logic [MAG_W-1:0] mag3_r [4];
  logic [3:0]       neg3_r;
  logic             deg3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag3_r[i] <= mag2_r[i] << sh2_r;
      end
      neg3_r <= neg2_r;
      deg3_r <= deg2_r;
    end
  end

  // Stage 4: squares.
  logic             v4_r;
  logic [SQ_W-1:0]  sq4_r [4];
  logic [MAG_W-1:0] mag4_r [4];
  logic [3:0]       neg4_r;
  logic             deg4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq4_r[i] <= SQ_W'(mag3_r[i]) * SQ_W'(mag3_r[i]);
      end
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
      deg4_r <= deg3_r;
    end
  end

  // Stages 5 and 6: sum of squares as a two level tree.
  logic             v5_r;
  logic [SQ_W:0]    p5_r [2];
  logic [MAG_W-1:0] mag5_r [4];
  logic [3:0]       neg5_r;
  logic             deg5_r;
  logic             v6_r;
  logic [N2_W-1:0]  n2_6_r;
  logic [MAG_W-1:0] mag6_r [4];
  logic [3:0]       neg6_r;
  logic             deg6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_r[0] <= (SQ_W + 1)'(sq4_r[0]) + (SQ_W + 1)'(sq4_r[1]);
      p5_r[1] <= (SQ_W + 1)'(sq4_r[2]) + (SQ_W + 1)'(sq4_r[3]);
      mag5_r  <= mag4_r;
      neg5_r  <= neg4_r;
      deg5_r  <= deg4_r;
      n2_6_r  <= N2_W'(p5_r[0]) + N2_W'(p5_r[1]);
      mag6_r  <= mag5_r;
      neg6_r  <= neg5_r;
      deg6_r  <= deg5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Square root of the sum of squares.
  logic             sq_v;
  logic [NRM_W-1:0] nrm;
  logic [PAY_W-1:0] sq_pay_in;
  logic [PAY_W-1:0] sq_pay;

  assign sq_pay_in = {mag6_r[3], mag6_r[2], mag6_r[1], mag6_r[0], neg6_r, deg6_r};

  rmq_sqrt #(
    .PAY_W(PAY_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v6_r),
    .in_rad   (n2_6_r),
    .in_pay   (sq_pay_in),
    .out_valid(sq_v),
    .out_root (nrm),
    .out_pay  (sq_pay)
  );

  // Division: index 0 is the set-up register, each later index one quotient bit.
  logic                  dv_r   [0:QW];
  logic [3:0][NRM_W-1:0] drem_r [0:QW];
  logic [3:0][QW-1:0]    dql_r  [0:QW];
  logic [NRM_W-1:0]      dnrm_r [0:QW];
  logic [3:0]            dneg_r [0:QW];
  logic                  ddeg_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    logic [MAG_W-1:0] m;
    logic [NW-1:0]    num;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        m   = sq_pay[5 + i*MAG_W +: MAG_W];
        // Adding half the norm gives rounding half away from zero.
        num = {m, FRAC_BITS'(0)} + NW'(nrm >> 1);
        drem_r[0][i] <= NRM_W'(num[NW-1:QW]);
        dql_r[0][i]  <= num[QW-1:0];
      end
      dnrm_r[0] <= nrm;
      dneg_r[0] <= sq_pay[4:1];
      ddeg_r[0] <= sq_pay[0];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      logic [NRM_W:0] t;
      logic           ge;
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          t  = {drem_r[k][i], dql_r[k][i][QW-1]};
          ge = (t >= {1'b0, dnrm_r[k]});
          drem_r[k+1][i] <= ge ? NRM_W'(t - {1'b0, dnrm_r[k]}) : NRM_W'(t);
          dql_r[k+1][i]  <= {dql_r[k][i][QW-2:0], ge};
        end
        dnrm_r[k+1] <= dnrm_r[k];
        dneg_r[k+1] <= dneg_r[k];
        ddeg_r[k+1] <= ddeg_r[k];
      end
    end
  end

  // Result register: sign, clamp, or the identity for a pivot that is not positive.
  out_item_t res_nxt;
  out_item_t out_r;

  always_comb begin
    logic [32:0]        qx;
    logic signed [15:0] v [4];
    for (int i = 0; i < 4; i++) begin
      qx = 33'(dql_r[QW][i]);
      if (dneg_r[QW][i]) begin
        v[i] = (qx > 33'd32768) ? -16'sd32768 : -$signed(qx[15:0]);
      end else begin
        v[i] = (qx > 33'd32767) ? 16'sh7fff : $signed(qx[15:0]);
      end
    end
    if (ddeg_r[QW]) begin
      res_nxt.quat_w     = IDENT_W;
      res_nxt.quat_x     = '0;
      res_nxt.quat_y     = '0;
      res_nxt.quat_z     = '0;
      res_nxt.degenerate = 1'b1;
    end else begin
      res_nxt.quat_w     = v[0];
      res_nxt.quat_x     = v[1];
      res_nxt.quat_y     = v[2];
      res_nxt.quat_z     = v[3];
      res_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the rotation matrix to quaternion block.
// Holds a quaternion predictor and scoreboard class, stimulus and checking tasks.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam int WATCH_LIMIT = 20000;

  class quat_scoreboard;
    out_item_t pending_q[$];
    int errors;

    function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function automatic out_item_t convert(in_item_t m);
      longint c[4];
      longint unsigned mag[4];
      longint unsigned mx, sumsq, nrm, q;
      longint unit, tr, pivot;
      out_item_t o;
      unit = 64'sd1 << FB;
      mx = 0;
      sumsq = 0;
      tr = longint'(m.r00) + m.r11 + m.r22;
      if (tr > 0) begin
        c[0] = tr + unit; c[1] = m.r21 - m.r12;
        c[2] = m.r02 - m.r20; c[3] = m.r10 - m.r01; pivot = c[0];
      end else if (m.r00 > m.r11 && m.r00 > m.r22) begin
        c[0] = m.r21 - m.r12; c[1] = unit + m.r00 - m.r11 - m.r22;
        c[2] = m.r01 + m.r10; c[3] = m.r02 + m.r20; pivot = c[1];
      end else if (m.r11 > m.r22) begin
        c[0] = m.r02 - m.r20; c[1] = m.r01 + m.r10;
        c[2] = unit + m.r11 - m.r00 - m.r22; c[3] = m.r12 + m.r21; pivot = c[2];
      end else begin
        c[0] = m.r10 - m.r01; c[1] = m.r02 + m.r20;
        c[2] = m.r12 + m.r21; c[3] = unit + m.r22 - m.r00 - m.r11; pivot = c[3];
      end
      if (pivot <= 0) begin
        o.quat_w = clamp16(unit);
        o.quat_x = '0; o.quat_y = '0; o.quat_z = '0;
        o.degenerate = 1'b1;
        return o;
      end
      for (int i = 0; i < 4; i++) begin
        mag[i] = (c[i] < 0) ? -c[i] : c[i];
        if (mag[i] > mx) mx = mag[i];
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 4; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 4; i++) sumsq += mag[i] * mag[i];
      nrm = root64(sumsq);
      for (int i = 0; i < 4; i++) begin
        q = ((mag[i] << FB) + (nrm >> 1)) / nrm;
        c[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      o.quat_w = clamp16(c[0]); o.quat_x = clamp16(c[1]);
      o.quat_y = clamp16(c[2]); o.quat_z = clamp16(c[3]);
      o.degenerate = 1'b0;
      return o;
    endfunction

    function void note_matrix(in_item_t m);
      pending_q.push_back(convert(m));
    endfunction

    function void check_quat(out_item_t got);
      out_item_t exp;
      if (pending_q.size() == 0) begin
        $error("quaternion arrived with none expected");
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.quat_w !== exp.quat_w) begin
        $error("quat_w expected %0d got %0d", exp.quat_w, got.quat_w); errors++;
      end
      if (got.quat_x !== exp.quat_x) begin
        $error("quat_x expected %0d got %0d", exp.quat_x, got.quat_x); errors++;
      end
      if (got.quat_y !== exp.quat_y) begin
        $error("quat_y expected %0d got %0d", exp.quat_y, got.quat_y); errors++;
      end
      if (got.quat_z !== exp.quat_z) begin
        $error("quat_z expected %0d got %0d", exp.quat_z, got.quat_z); errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate expected %0d got %0d", exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_item_t in_data = '0;
  out_item_t out_data;

  quat_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  // Checking and the receiver's pop pattern; a long hold counts down here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_quat(out_data);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom_range(32767) - 16384);
      3: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  // Near-rotation built from a random unit quaternion, with small noise.
  function automatic in_item_t rand_rotation();
    real a, b, c, d, n;
    real e[9];
    in_item_t m;
    a = $urandom_range(20000) - 10000.0; b = $urandom_range(20000) - 10000.0;
    c = $urandom_range(20000) - 10000.0; d = $urandom_range(20000) - 10000.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1e-9;
    a /= n; b /= n; c /= n; d /= n;
    e[0] = 1 - 2 * (c * c + d * d); e[1] = 2 * (b * c - a * d); e[2] = 2 * (b * d + a * c);
    e[3] = 2 * (b * c + a * d); e[4] = 1 - 2 * (b * b + d * d); e[5] = 2 * (c * d - a * b);
    e[6] = 2 * (b * d - a * c); e[7] = 2 * (c * d + a * b); e[8] = 1 - 2 * (b * b + c * c);
    m.r00 = 16'($rtoi(e[0] * 16384) + $urandom_range(6) - 3);
    m.r01 = 16'($rtoi(e[1] * 16384) + $urandom_range(6) - 3);
    m.r02 = 16'($rtoi(e[2] * 16384) + $urandom_range(6) - 3);
    m.r10 = 16'($rtoi(e[3] * 16384) + $urandom_range(6) - 3);
    m.r11 = 16'($rtoi(e[4] * 16384) + $urandom_range(6) - 3);
    m.r12 = 16'($rtoi(e[5] * 16384) + $urandom_range(6) - 3);
    m.r20 = 16'($rtoi(e[6] * 16384) + $urandom_range(6) - 3);
    m.r21 = 16'($rtoi(e[7] * 16384) + $urandom_range(6) - 3);
    m.r22 = 16'($rtoi(e[8] * 16384) + $urandom_range(6) - 3);
    return m;
  endfunction

  function automatic in_item_t rand_matrix();
    in_item_t m;
    if ($urandom_range(3) != 0) return rand_rotation();
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    return m;
  endfunction

  // Offers one matrix, with random idle cycles first, and waits for acceptance.
  task automatic send_matrix(in_item_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_matrix(m);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t mat(int a, int b, int c, int d, int e, int f,
                                   int g, int h, int i);
    in_item_t m;
    m.r00 = 16'(a); m.r01 = 16'(b); m.r02 = 16'(c); m.r10 = 16'(d); m.r11 = 16'(e);
    m.r12 = 16'(f); m.r20 = 16'(g); m.r21 = 16'(h); m.r22 = 16'(i);
    return m;
  endfunction

  initial begin
    in_item_t directed[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity, half turns about each axis, a quarter turn, ties and bad pivots.
    directed.push_back(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    directed.push_back(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    directed.push_back(mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    directed.push_back(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    directed.push_back(mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    directed.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    directed.push_back(mat(-8192, 100, 0, 0, -8192, 0, 0, 0, -16384));
    directed.push_back(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    directed.push_back(mat(-32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768, -32768));
    directed.push_back(mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    directed.push_back(mat(-32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    directed.push_back(mat(-30000, 0, 0, 0, -30000, 0, 0, 0, -30000));
    directed.push_back(mat(-32768, 0, 0, 0, -32768, 0, 0, 0, 0));
    directed.push_back(mat(0, 16384, 0, 16384, 0, 0, 0, 0, -16384));
    directed.push_back(mat(-16384, 0, 0, 0, 0, 16384, 0, 16384, 0));
    directed.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(mat(-1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mat(21845, 21845, -21845, 0, 1, 2, 3, 4, 5));
    directed.push_back(mat(-5000, 12000, 300, -12000, -5000, 7, 9, 11, -5000));
    foreach (directed[k]) send_matrix(directed[k]);
    drain_results();

    // Long receiver hold while the sender keeps offering, to fill the block.
    hold_cycles = 300;
    for (int k = 0; k < 150; k++) send_matrix(rand_matrix());
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int k = 0; k < 345; k++) send_matrix(rand_matrix());
      // The sender pauses here until every expected quaternion has come.
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
